FILE: sv/rcmm_ir_frame_encoder_defines.svh
// Assertion helpers for the RCMM encoder.
`ifndef RCMM_IR_FRAME_ENCODER_DEFINES_SVH
`define RCMM_IR_FRAME_ENCODER_DEFINES_SVH

// Clocked check, quiet while reset is held.
`define RCMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RCMM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/rcmm_pkg.sv
package rcmm_pkg;

    // configuration register widths and indexes
    localparam int UNIT_W   = 10;
    localparam int HDR_W    = 12;
    localparam int GAP_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd2;

    localparam logic [UNIT_W-1:0] UNIT_RST   = 10'd290;
    localparam logic [HDR_W-1:0]  HEADER_RST = 12'd1000;
    localparam logic [GAP_W-1:0]  GAP_RST    = 16'd30000;

    // payload
    localparam int DEV_W   = 8;
    localparam int FN_W    = 8;
    localparam int REP_W   = 3;
    localparam int IN_W    = 24;
    localparam int WORD_W  = 20;
    localparam int SYM_W   = 2;

    localparam int MARK_W  = 12;
    localparam int SPACE_W = 16;
    localparam int OUT_W   = 32;

    localparam logic [REP_W-1:0] MAX_REPEATS = 3'd4;

    // pair sequencing within a frame
    localparam int PAIR_W = 4;
    localparam logic [PAIR_W-1:0] PAIR_HEADER = 4'd0;
    localparam logic [PAIR_W-1:0] PAIR_TRAIL  = 4'd11;

    // 4-bit checksum: XOR of all nibbles of both bytes
    function automatic logic [3:0] csum4(input logic [DEV_W-1:0] dev,
                                         input logic [FN_W-1:0]  fn);
        csum4 = dev[7:4] ^ dev[3:0] ^ fn[7:4] ^ fn[3:0];
    endfunction

endpackage

FILE: sv/rcmm_ir_frame_encoder.sv
//  channel   | direction | handshake                        | payload
//  ----------+-----------+----------------------------------+------------------------------
//  request   | in        | i_s_axis_tvalid / o_s_axis_tready| device, function_req, repeats
//  timing    | out       | o_m_axis_tvalid / i_m_axis_tready| mark_us, space_us, tlast=last
//  config    | in        | i_cfg_we (no back-pressure)      | i_cfg_idx, i_cfg_data
//
//  A request sends 1 + min(repeats, 4) frames of 12 pairs: 12 to 60 pairs, one per cycle
//  when the sink keeps up; the pair sequencer sets the pace.
//  The 20-bit word sits in a rotating shift register, two bits leave per symbol pair.
//  Reset (synchronous, active low) idles the sequencer and restores the default timings.
//  A stall on the timing side freezes the sequencer; the next request is taken as soon
//  as the last pair is in the output register, even if it has not been taken yet.
module rcmm_ir_frame_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [7:0] device, [15:8] function_req, [18:16] repeats, [23:19] zero
    input  logic [rcmm_pkg::IN_W-1:0]     i_s_axis_tdata,
    // timing pairs
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [11:0] mark_us, [27:12] space_us, [31:28] zero
    output logic [rcmm_pkg::OUT_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [rcmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcmm_pkg::CFG_W-1:0]    i_cfg_data
);
    import rcmm_pkg::*;
    `include "rcmm_ir_frame_encoder_defines.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration registers
    logic [UNIT_W-1:0] r_unit;
    logic [HDR_W-1:0]  r_header;
    logic [GAP_W-1:0]  r_gap;

    // sequencer
    logic              r_state, n_state;
    logic [PAIR_W-1:0] r_pair, n_pair;
    logic [REP_W-1:0]  r_frames_left, n_frames_left;
    logic [WORD_W-1:0] r_word, n_word;

    // output register
    logic               r_ovalid, n_ovalid;
    logic [MARK_W-1:0]  r_mark, n_mark;
    logic [SPACE_W-1:0] r_space, n_space;
    logic               r_last, n_last;

    logic s_acc;
    logic slot_free;
    logic [DEV_W-1:0] in_dev;
    logic [FN_W-1:0]  in_fn;
    logic [REP_W-1:0] in_rep;
    logic [SYM_W-1:0] sym;
    logic [MARK_W-1:0]  sym_mark;
    logic [SPACE_W-1:0] sym_space;
    logic [SPACE_W-1:0] unit_x;

    assign in_dev = i_s_axis_tdata[DEV_W-1:0];
    assign in_fn  = i_s_axis_tdata[DEV_W+FN_W-1:DEV_W];
    assign in_rep = i_s_axis_tdata[DEV_W+FN_W+REP_W-1:DEV_W+FN_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_ovalid || i_m_axis_tready;

    // current symbol is the top digit of the rotating word
    assign sym      = r_word[WORD_W-1 -: SYM_W];
    assign unit_x   = SPACE_W'(r_unit);
    assign sym_mark = MARK_W'({r_unit, 1'b0});
    // (2 + sym) * unit by shift and add
    assign sym_space = (unit_x << 1)
                     + (sym[0] ? unit_x : '0)
                     + (sym[1] ? (unit_x << 1) : '0);

    always_comb begin
        n_state       = r_state;
        n_pair        = r_pair;
        n_frames_left = r_frames_left;
        n_word        = r_word;
        n_ovalid      = r_ovalid && !i_m_axis_tready;
        n_mark        = r_mark;
        n_space       = r_space;
        n_last        = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state       = ST_RUN;
                    n_pair        = PAIR_HEADER;
                    n_word        = {in_dev, in_fn, csum4(in_dev, in_fn)};
                    n_frames_left = (in_rep > MAX_REPEATS) ? MAX_REPEATS : in_rep;
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_last   = 1'b0;
                    n_pair   = r_pair + PAIR_W'(1);
                    priority if (r_pair == PAIR_HEADER) begin
                        n_mark  = r_header;
                        n_space = SPACE_W'({r_unit, 1'b0});
                    end else if (r_pair == PAIR_TRAIL) begin
                        n_mark = sym_mark;
                        n_pair = PAIR_HEADER;
                        if (r_frames_left == '0) begin
                            n_space = '0;
                            n_last  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_space       = r_gap;
                            n_frames_left = r_frames_left - REP_W'(1);
                        end
                    end else begin
                        n_mark  = sym_mark;
                        n_space = sym_space;
                        // rotate: after ten symbols the word is back for a repeat
                        n_word  = {r_word[WORD_W-SYM_W-1:0], r_word[WORD_W-1 -: SYM_W]};
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pair        <= PAIR_HEADER;
            r_frames_left <= '0;
            r_ovalid      <= 1'b0;
            r_unit        <= UNIT_RST;
            r_header      <= HEADER_RST;
            r_gap         <= GAP_RST;
        end else begin
            r_state       <= n_state;
            r_pair        <= n_pair;
            r_frames_left <= n_frames_left;
            r_ovalid      <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_UNIT:   r_unit   <= i_cfg_data[UNIT_W-1:0];
                    REG_HEADER: r_header <= i_cfg_data[HDR_W-1:0];
                    REG_GAP:    r_gap    <= i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_mark  <= n_mark;
        r_space <= n_space;
        r_last  <= n_last;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tdata  = {{(OUT_W-MARK_W-SPACE_W){1'b0}}, r_space, r_mark};

    `RCMM_ASSERT(a_start_at_header, s_acc |=> (r_state == ST_RUN && r_pair == PAIR_HEADER), "request did not start a frame at the header pair")
    `RCMM_ASSERT(a_stall_freezes, (r_ovalid && !i_m_axis_tready) |=> $stable(r_pair), "sequencer moved while the output was stalled")
    `RCMM_ASSERT(a_mid_frame_running, (r_pair != PAIR_HEADER) |-> (r_state == ST_RUN), "idle in the middle of a frame")
    `RCMM_ASSERT(a_frames_bounded, r_frames_left <= MAX_REPEATS, "repeat count above limit")
endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rcmm_pkg::*;

    // index with no register behind it: writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // watchdog limit while no handshake moves at all
    localparam int STALL_LIMIT = 2000;
    // cycles of quiet after the last pair before touching the registers
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES = 8;
    localparam int PHASE_REQS = 46;

    typedef struct packed {
        logic [MARK_W-1:0]  mark;
        logic [SPACE_W-1:0] space;
        logic               fin;
    } pair_t;

    // stimulus, all driven from time zero
    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_valid   = 1'b0;
    logic [IN_W-1:0]      s_data    = '0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    // shadow copy of the timing registers
    logic [UNIT_W-1:0]    unit_cfg = UNIT_RST;
    logic [HDR_W-1:0]     hdr_cfg  = HEADER_RST;
    logic [GAP_W-1:0]     gap_cfg  = GAP_RST;

    pair_t                pair_q[$];   // timing pairs still owed by the encoder

    int unsigned          req_cnt   = 0;
    int unsigned          pair_cnt  = 0;
    int unsigned          cfg_cnt   = 0;
    int unsigned          err_cnt   = 0;
    int unsigned          stall_cnt = 0;

    bit                   src_idle_en = 1'b1;
    bit                   snk_idle_en = 1'b1;

    rcmm_ir_frame_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame encoder prediction
    // ------------------------------------------------------------------
    function automatic void push_pair(input logic [MARK_W-1:0] mark,
                                      input logic [SPACE_W-1:0] space, input logic fin);
        pair_t p;
        p.mark  = mark;
        p.space = space;
        p.fin   = fin;
        pair_q.push_back(p);
    endfunction

    // header, ten 2-bit symbols MSB first, trailer; frame sent 1 + sat(repeats) times
    function automatic void encode_frames(input logic [DEV_W-1:0] dev,
                                          input logic [FN_W-1:0] fn,
                                          input logic [REP_W-1:0] rep);
        logic [3:0]        chk;
        logic [WORD_W-1:0] word;
        logic [REP_W-1:0]  extra;
        logic [MARK_W-1:0] sym_mark;
        logic [1:0]        sym;
        chk      = 4'((dev >> 4) ^ dev ^ (fn >> 4) ^ fn);
        word     = {dev, fn, chk};
        extra    = (rep > MAX_REPEATS) ? MAX_REPEATS : rep;
        sym_mark = MARK_W'(2 * unit_cfg);
        for (int f = 0; f <= extra; f++) begin
            push_pair(hdr_cfg, SPACE_W'(2 * unit_cfg), 1'b0);
            for (int s = 0; s < 10; s++) begin
                sym = word[WORD_W-1-2*s -: 2];
                push_pair(sym_mark, SPACE_W'((2 + sym) * unit_cfg), 1'b0);
            end
            // final frame closes with a zero space and tlast
            if (f == extra)
                push_pair(sym_mark, '0, 1'b1);
            else
                push_pair(sym_mark, gap_cfg, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Called right after an edge. Leaves tvalid high on return; the caller
    // follows with another request or hold_requests in the same step.
    task automatic send_request(input logic [DEV_W-1:0] dev, input logic [FN_W-1:0] fn,
                                input logic [REP_W-1:0] rep);
        int unsigned gap;
        gap = 0;
        while (src_idle_en && $urandom_range(0, 99) < 24)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(IN_W-DEV_W-FN_W-REP_W){1'b0}}, rep, fn, dev};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        encode_frames(dev, fn, rep);
        req_cnt++;
    endtask

    task automatic hold_requests();
        s_valid <= 1'b0;
    endtask

    // sender stops until every owed pair has been taken
    task automatic wait_idle();
        hold_requests();
        while (pair_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only while the encoder is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_UNIT:   unit_cfg = data[UNIT_W-1:0];
            REG_HEADER: hdr_cfg  = data[HDR_W-1:0];
            REG_GAP:    gap_cfg  = data[GAP_W-1:0];
            default: ;  // spare index, dropped
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Timing side: random back-pressure and pair checker
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        m_ready <= !snk_idle_en || ($urandom_range(0, 99) >= 24);

    task automatic report_mismatch(input string what);
        $display("%0t: pair %0d: %s", $time, pair_cnt, what);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        pair_t want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (pair_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pair mark %0d space %0d tlast %0b",
                    o_m_axis_tdata[MARK_W-1:0], o_m_axis_tdata[MARK_W +: SPACE_W],
                    o_m_axis_tlast));
            end else begin
                want = pair_q.pop_front();
                if (o_m_axis_tdata[MARK_W-1:0] !== want.mark)
                    report_mismatch($sformatf("mark %0d, want %0d",
                        o_m_axis_tdata[MARK_W-1:0], want.mark));
                if (o_m_axis_tdata[MARK_W +: SPACE_W] !== want.space)
                    report_mismatch($sformatf("space %0d, want %0d",
                        o_m_axis_tdata[MARK_W +: SPACE_W], want.space));
                if (o_m_axis_tlast !== want.fin)
                    report_mismatch($sformatf("tlast %0b, want %0b",
                        o_m_axis_tlast, want.fin));
                if (o_m_axis_tdata[OUT_W-1:MARK_W+SPACE_W] !== '0)
                    report_mismatch("tdata padding not zero");
            end
            pair_cnt++;
        end
    end

    // watchdog: nothing moved on any port for too long
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset timings: 290 us unit, 1000 us header, 30000 us gap
    task automatic test_reset_timing();
        send_request(8'h00, 8'h00, 3'd0);
        send_request(8'hFF, 8'hFF, 3'd0);
        wait_idle();
    endtask

    // byte extremes, alternating symbol patterns, repeat counts 1 to 7 incl. saturation
    task automatic test_field_extremes();
        send_request(8'h00, 8'hFF, 3'd1);
        send_request(8'hFF, 8'h00, 3'd2);
        send_request(8'hA5, 8'h5A, 3'd3);
        send_request(8'h5A, 8'hA5, 3'd4);
        send_request(8'h12, 8'h34, 3'd5);
        send_request(8'hC3, 8'h3C, 3'd6);
        send_request(8'h81, 8'h7E, 3'd7);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // smallest legal timings, no gap between frames
        write_reg(REG_UNIT, 16'd1);
        write_reg(REG_HEADER, 16'd1);
        write_reg(REG_GAP, 16'd0);
        send_request(8'hE4, 8'h1B, 3'd2);
        wait_idle();
        // largest timings
        write_reg(REG_UNIT, 16'd1023);
        write_reg(REG_HEADER, 16'd4095);
        write_reg(REG_GAP, 16'hFFFF);
        send_request(8'hFF, 8'hFF, 3'd4);
        wait_idle();
        // out-of-range zero unit and header
        write_reg(REG_UNIT, 16'd0);
        write_reg(REG_HEADER, 16'd0);
        send_request(8'h96, 8'h69, 3'd1);
        wait_idle();
        // spare index must leave the zeros in place
        write_reg(REG_SPARE, 16'hFFFF);
        send_request(8'h3C, 8'hC3, 3'd0);
        wait_idle();
        // over-wide data, upper bits dropped
        write_reg(REG_UNIT, 16'hFFFF);
        write_reg(REG_HEADER, 16'hF123);
        write_reg(REG_GAP, 16'd30000);
        send_request(8'h01, 8'h80, 3'd1);
        wait_idle();
    endtask

    function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    task automatic test_random_traffic();
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_UNIT, CFG_W'(pick_value(1, 1023)));
            write_reg(REG_HEADER, CFG_W'(pick_value(1, 4095)));
            write_reg(REG_GAP, CFG_W'(pick_value(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, CFG_W'($urandom));
            // one phase runs flat out on both sides
            src_idle_en = (ph != 3);
            snk_idle_en = (ph != 3);
            for (int n = 0; n < PHASE_REQS; n++) begin
                // sender holds off mid-phase until the encoder drains
                if (ph == 5 && n == PHASE_REQS / 2)
                    wait_idle();
                send_request(DEV_W'($urandom), FN_W'($urandom),
                             REP_W'($urandom_range(0, 7)));
            end
            wait_idle();
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_timing();
        test_field_extremes();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        repeat (16) @(posedge i_clk);

        $display("Ran %0d requests giving %0d timing pairs, %0d register writes.",
                 req_cnt, pair_cnt, cfg_cnt);
        $display("Covered repeat saturation, zero and full-scale timings, spare index, "
                 , "sender drain and unthrottled traffic.");
        if (err_cnt == 0 && pair_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
